>>> rtl/core/soia_pkg.sv
// Shared types and constants for the six-operation integer ALU.
package soia_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned CmdWidth  = 3;
   localparam int unsigned StatWidth = 2;
   localparam int unsigned DivSteps  = 4;
   localparam int unsigned BitsPerStep = DataWidth / DivSteps;

   typedef enum logic [CmdWidth-1:0] {
      CMD_ADD = 3'd0,
      CMD_SUB = 3'd1,
      CMD_MUL = 3'd2,
      CMD_SRA = 3'd3,
      CMD_DIV = 3'd4,
      CMD_NOT = 3'd5,
      CMD_RSV6 = 3'd6,
      CMD_RSV7 = 3'd7
   } cmd_type;

   typedef enum logic [StatWidth-1:0] {
      ST_OK      = 2'd0,
      ST_DIVZERO = 2'd1,
      ST_UNKNOWN = 2'd2,
      ST_RSV     = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type              cmd;
      logic                 neg_q;
      logic                 div_zero;
      logic [DataWidth-1:0] rem;
      logic [DataWidth-1:0] quo;
      logic [DataWidth-1:0] divisor;
      logic [DataWidth-1:0] res;
   } stage_type;

endpackage

>>> rtl/core/soia_div_step.sv
// One divide stage: a group of restoring divide iterations plus a stage register.
module soia_div_step (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 valid_in,
   input  soia_pkg::stage_type  stage_in,
   output logic                 valid_out,
   output soia_pkg::stage_type  stage_out
);

   logic                valid_ff;
   soia_pkg::stage_type stage_ff;
   soia_pkg::stage_type stage_in_c;
   logic [soia_pkg::DataWidth:0] trial;
   logic [soia_pkg::DataWidth-1:0] rem_v;
   logic [soia_pkg::DataWidth-1:0] quo_v;

   always_comb begin
      stage_in_c = stage_in;
      rem_v = stage_in.rem;
      quo_v = stage_in.quo;
      trial = '0;
      for (int i = 0; i < int'(soia_pkg::BitsPerStep); i++) begin
         trial = {rem_v, quo_v[soia_pkg::DataWidth-1]} - {1'b0, stage_in.divisor};
         if (!trial[soia_pkg::DataWidth]) begin
            rem_v = trial[soia_pkg::DataWidth-1:0];
            quo_v = {quo_v[soia_pkg::DataWidth-2:0], 1'b1};
         end else begin
            rem_v = {rem_v[soia_pkg::DataWidth-2:0], quo_v[soia_pkg::DataWidth-1]};
            quo_v = {quo_v[soia_pkg::DataWidth-2:0], 1'b0};
         end
      end
      stage_in_c.rem = rem_v;
      stage_in_c.quo = quo_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         stage_ff <= stage_in_c;
      end
   end

   assign valid_out = valid_ff;
   assign stage_out = stage_ff;

endmodule

>>> rtl/core/six_op_integer_alu.sv
// Top level of the six-operation integer ALU pipeline.
// Pipelined ALU built from six register stages: the input stage, four divide stages
// and the output register. With rsp_ready held high it takes one transfer per cycle.
// Stage 1 decodes, computes add/sub/shift/not and the multiplier product, and takes
// operand magnitudes for divide; four stages each run eight restoring divide
// iterations; the last stage fixes the quotient sign and picks the result. The
// whole pipe advances when the output register is empty or being taken, so a
// stall holds every stage and loses nothing. Divide truncates toward zero; divide
// by zero gives 0 with status 1; unknown opcodes give 0 with status 2.
module six_op_integer_alu (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [soia_pkg::CmdWidth-1:0]      req_cmd,
   input  logic signed [soia_pkg::DataWidth-1:0] req_operand_a,
   input  logic signed [soia_pkg::DataWidth-1:0] req_operand_b,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [soia_pkg::DataWidth-1:0] rsp_result,
   output logic [soia_pkg::StatWidth-1:0]     rsp_status
);

   localparam int unsigned W = soia_pkg::DataWidth;

   logic advance;
   soia_pkg::stage_type s0_in;
   logic [W-1:0] ma, mb, sra_v;
   logic [W-1:0] amt_lo;
   logic big_amt;

   logic                v_ff   [soia_pkg::DivSteps+1];
   soia_pkg::stage_type st_ff  [soia_pkg::DivSteps+1];

   logic rsp_valid_ff;
   logic [W-1:0] rsp_result_ff, rsp_result_in;
   soia_pkg::status_type rsp_status_ff, rsp_status_in;

   // Advance whenever the output slot is free or being taken.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // Stage 1 work: everything except the divide iterations and the final quotient sign fix and status select.
   always_comb begin
      ma = req_operand_a[W-1] ? W'(-req_operand_a) : req_operand_a;
      mb = req_operand_b[W-1] ? W'(-req_operand_b) : req_operand_b;
      amt_lo = req_operand_b;
      big_amt = amt_lo >= W'(W - 1);
      sra_v = big_amt ? {W{req_operand_a[W-1]}} : W'(req_operand_a >>> amt_lo[$clog2(W)-1:0]);
      s0_in.cmd      = soia_pkg::cmd_type'(req_cmd);
      s0_in.neg_q    = req_operand_a[W-1] ^ req_operand_b[W-1];
      s0_in.div_zero = req_operand_b == '0;
      s0_in.rem      = '0;
      s0_in.quo      = ma;
      s0_in.divisor  = mb;
      unique case (soia_pkg::cmd_type'(req_cmd))
         soia_pkg::CMD_ADD: s0_in.res = W'(req_operand_a + req_operand_b);
         soia_pkg::CMD_SUB: s0_in.res = W'(req_operand_a - req_operand_b);
         soia_pkg::CMD_MUL: s0_in.res = W'(req_operand_a * req_operand_b);
         soia_pkg::CMD_SRA: s0_in.res = sra_v;
         soia_pkg::CMD_NOT: s0_in.res = ~req_operand_a;
         default:           s0_in.res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (advance) begin
         v_ff[0] <= req_valid;
      end
      if (advance) begin
         st_ff[0] <= s0_in;
      end
   end

   // Divide stages, each carrying the other operations' result alongside.
   for (genvar g = 0; g < int'(soia_pkg::DivSteps); g++) begin : g_div
      soia_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (v_ff[g]),
         .stage_in  (st_ff[g]),
         .valid_out (v_ff[g+1]),
         .stage_out (st_ff[g+1])
      );
   end

   // Final select: sign-fix the quotient and choose the result and status.
   always_comb begin
      rsp_status_in = soia_pkg::ST_OK;
      rsp_result_in = st_ff[soia_pkg::DivSteps].res;
      unique case (st_ff[soia_pkg::DivSteps].cmd)
         soia_pkg::CMD_DIV: begin
            if (st_ff[soia_pkg::DivSteps].div_zero) begin
               rsp_result_in = '0;
               rsp_status_in = soia_pkg::ST_DIVZERO;
            end else if (st_ff[soia_pkg::DivSteps].neg_q) begin
               rsp_result_in = W'(-st_ff[soia_pkg::DivSteps].quo);
            end else begin
               rsp_result_in = st_ff[soia_pkg::DivSteps].quo;
            end
         end
         soia_pkg::CMD_RSV6, soia_pkg::CMD_RSV7: begin
            rsp_result_in = '0;
            rsp_status_in = soia_pkg::ST_UNKNOWN;
         end
         default: begin
            rsp_status_in = soia_pkg::ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= v_ff[soia_pkg::DivSteps];
      end
      if (advance) begin
         rsp_result_ff <= rsp_result_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;
   assign rsp_status = rsp_status_ff;

`ifndef SYNTHESIS
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result) && $stable(rsp_status))
      else $error("output changed while stalled");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != soia_pkg::ST_RSV)
      else $error("reserved status code");
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != soia_pkg::ST_OK |-> rsp_result == '0)
      else $error("error result not zero");
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");
`endif

endmodule
